>>> rtl/iti_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iti_pkg: shared types and constants of the IMU timestamp interpolator
// Depths, field widths and the payload structures of both channels.
// ----------------------------------------------------------------------------
package iti_pkg;

    localparam int SampleDepth  = 32;
    localparam int RequestDepth = 8;
    localparam int SampAw = (SampleDepth > 1) ? $clog2(SampleDepth) : 1;
    localparam int ReqAw  = (RequestDepth > 1) ? $clog2(RequestDepth) : 1;
    localparam int SampCw = $clog2(SampleDepth + 1);
    localparam int ReqCw  = $clog2(RequestDepth + 1);

    localparam logic OP_SAMPLE  = 1'b0;
    localparam logic OP_REQUEST = 1'b1;
    localparam logic KIND_PASS   = 1'b0;
    localparam logic KIND_INTERP = 1'b1;

    typedef struct packed {
        logic               opcode;
        logic        [31:0] stamp;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] rate_x;
        logic signed [15:0] rate_y;
        logic signed [15:0] rate_z;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
    } t_in_item;

    typedef struct packed {
        logic               kind;
        logic        [31:0] out_stamp;
        logic signed [15:0] out_accel_x;
        logic signed [15:0] out_accel_y;
        logic signed [15:0] out_accel_z;
        logic signed [15:0] out_rate_x;
        logic signed [15:0] out_rate_y;
        logic signed [15:0] out_rate_z;
        logic signed [15:0] out_quat_x;
        logic signed [15:0] out_quat_y;
        logic signed [15:0] out_quat_z;
        logic signed [15:0] out_quat_w;
    } t_out_item;

    // A stored sample: stamp then ten 16-bit values.
    typedef struct packed {
        logic        [31:0] stamp;
        logic [9:0][15:0]   vals;
    } t_sample;

endpackage
`default_nettype wire

>>> rtl/iti_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iti_in_if / iti_out_if: valid/ready channels of the interpolator
// Each carries valid, ready and one payload structure.
// ----------------------------------------------------------------------------
interface iti_in_if;
    logic               valid;
    logic               ready;
    iti_pkg::t_in_item  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface iti_out_if;
    logic               valid;
    logic               ready;
    iti_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/imu_timestamp_interpolator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// imu_timestamp_interpolator: aligns IMU samples to requested sync times
// Stores samples and sync times in FIFOs, passes older samples through and
// emits one linearly interpolated sample, with normalized quaternion, per
// bracketed sync time.
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  i_in      sink       opcode, stamp, accel, rate, quat
//  o_out     source     kind, out_stamp, accel, rate, quat
//
// An input is stored as it is taken; each look at the FIFO heads runs the
// read state and then the check state, and a pass-through sample the pass
// state plus its output transfer. An interpolation runs ten divisions on
// the shared divider (none when the bracket stamps are equal), then four
// root searches of up to 15 bisection steps each. Reset empties both FIFOs;
// no clearing pass.
// The block takes no input until the sequencer is back in idle, and waits in
// place while the output is stalled.
module imu_timestamp_interpolator (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    iti_in_if.sink    i_in,
    iti_out_if.source o_out
);
    localparam int SAw = iti_pkg::SampAw;
    localparam int RAw = iti_pkg::ReqAw;
    localparam int SCw = iti_pkg::SampCw;
    localparam int RCw = iti_pkg::ReqCw;

    localparam logic [1:0] RD_OLD    = 2'd0;
    localparam logic [1:0] RD_SECOND = 2'd1;
    localparam logic [1:0] RD_NEW    = 2'd2;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_CHECK = 11'b00000000010,
        S_RD    = 11'b00000000100,
        S_PASS  = 11'b00000001000,
        S_LDIV  = 11'b00000010000,
        S_DIVGO = 11'b00000100000,
        S_WDIV  = 11'b00001000000,
        S_SUMSQ = 11'b00010000000,
        S_NMUL  = 11'b00100000000,
        S_NCMP  = 11'b01000000000,
        S_EMIT  = 11'b10000000000
    } t_state;

    t_state r_state;

    // Sample and request memories.
    iti_pkg::t_sample r_smem [iti_pkg::SampleDepth];
    logic [31:0]      r_rmem [iti_pkg::RequestDepth];
    logic [SAw-1:0]   r_shead;
    logic [SCw-1:0]   r_sfill;
    logic [RAw-1:0]   r_rhead;
    logic [RCw-1:0]   r_rfill;

    // Stamps of oldest, second and newest sample, and the head request.
    logic [31:0] r_f, r_b, r_last, r_t;
    iti_pkg::t_sample r_vf, r_vb, r_rdata;
    logic [1:0]       r_rdsel;

    logic [9:0][15:0] r_vi;
    logic [3:0]       r_idx;
    logic             r_neg;
    logic [33:0]      r_s;
    logic [14:0]      r_lo, r_hi;
    logic [63:0]      r_prod;
    logic [63:0]      r_a2;
    iti_pkg::t_out_item r_out;
    logic               r_ovalid;

    logic [SAw-1:0] w_wslot;
    logic [SAw-1:0] w_slot1;
    logic [SAw-1:0] w_slotl;
    logic [RAw-1:0] w_rslot;
    logic [SAw:0]   w_sum_s;
    logic [RAw:0]   w_sum_r;
    logic           w_sfull;
    logic           w_accept;

    // Divider interface
    logic        w_dstart;
    logic [63:0] w_dnum, w_dden;
    logic        w_ddone;
    logic [63:0] w_dquot;
    logic [31:0] w_den, w_n, w_dmn;

    function automatic logic [SAw-1:0] f_swrap(input logic [SAw:0] v);
        logic [SAw:0] t;
        t = v - (SAw+1)'(iti_pkg::SampleDepth);
        return (v >= (SAw+1)'(iti_pkg::SampleDepth)) ? t[SAw-1:0] : v[SAw-1:0];
    endfunction

    function automatic logic [RAw-1:0] f_rwrap(input logic [RAw:0] v);
        logic [RAw:0] t;
        t = v - (RAw+1)'(iti_pkg::RequestDepth);
        return (v >= (RAw+1)'(iti_pkg::RequestDepth)) ? t[RAw-1:0] : v[RAw-1:0];
    endfunction

    assign w_sfull  = (r_sfill == SCw'(iti_pkg::SampleDepth));
    assign w_accept = i_in.valid && i_in.ready;
    // A result still waiting in the output register does not hold off input;
    // the sequencer waits for it before it writes the next one.
    assign i_in.ready = (r_state == S_IDLE);

    logic [SAw-1:0] w_head_eff;
    logic [SCw-1:0] w_fill_eff;
    assign w_head_eff = w_sfull ? f_swrap({1'b0, r_shead} + (SAw+1)'(1)) : r_shead;
    assign w_fill_eff = w_sfull ? r_sfill - SCw'(1) : r_sfill;
    assign w_sum_s = {1'b0, w_head_eff} + (SAw+1)'(w_fill_eff);
    assign w_wslot = f_swrap(w_sum_s);
    assign w_slot1 = f_swrap({1'b0, r_shead} + (SAw+1)'(1));
    assign w_slotl = f_swrap({1'b0, r_shead} + (SAw+1)'(r_sfill - SCw'(1)));
    assign w_sum_r = {1'b0, r_rhead} + (RAw+1)'(r_rfill);
    assign w_rslot = f_rwrap(w_sum_r);

    // Lerp operands for the current component.
    logic signed [15:0] w_vfc, w_vbc;
    logic signed [49:0] w_lnum;
    logic [49:0]        w_lmag;
    assign w_den = r_b - r_f;
    assign w_n   = r_t - r_f;
    assign w_dmn = r_b - r_t;
    assign w_vfc = r_vf.vals[r_idx];
    assign w_vbc = r_vb.vals[r_idx];
    // Products of 16 by 33 bits, registered in r_prod before division.
    assign w_lnum = 50'(w_vfc) * $signed({18'd0, w_dmn})
                  + 50'(w_vbc) * $signed({18'd0, w_n});
    assign w_lmag = w_lnum[49] ? -w_lnum : w_lnum;

    logic [15:0] w_qc;
    logic [15:0] w_qabs;
    logic [31:0] w_qsq;
    assign w_qc   = r_vi[r_idx];
    assign w_qabs = w_qc[15] ? -w_qc : w_qc;
    assign w_qsq  = {16'd0, w_qabs} * {16'd0, w_qabs};

    logic [14:0] w_mid;
    logic [15:0] w_mid_sum;
    logic [15:0] w_todd;
    logic [31:0] w_tsq;
    logic [63:0] w_tts;
    assign w_mid_sum = ({1'b0, r_lo} + {1'b0, r_hi} + 16'd1);
    assign w_mid     = w_mid_sum[15:1];
    assign w_todd    = {w_mid, 1'b0} - 16'd1;
    assign w_tsq     = {16'd0, w_todd} * {16'd0, w_todd};
    assign w_tts     = 64'(r_prod[29:0]) * 64'(r_s);

    assign w_dnum = {13'd0, r_prod[49:0], 1'b0} + {32'd0, w_den};
    assign w_dden = {31'd0, w_den, 1'b0};
    assign w_dstart = (r_state == S_DIVGO);

    iti_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_dstart),
        .i_num   (w_dnum),
        .i_den   (w_dden),
        .o_done  (w_ddone),
        .o_quot  (w_dquot)
    );

    always_ff @(posedge i_clk) begin
        if (w_accept && i_in.data.opcode == iti_pkg::OP_SAMPLE) begin
            r_smem[w_wslot] <= {i_in.data.stamp, i_in.data.accel_x, i_in.data.accel_y,
                                i_in.data.accel_z, i_in.data.rate_x, i_in.data.rate_y,
                                i_in.data.rate_z, i_in.data.quat_x, i_in.data.quat_y,
                                i_in.data.quat_z, i_in.data.quat_w};
        end
        if (w_accept && i_in.data.opcode == iti_pkg::OP_REQUEST &&
            r_rfill != RCw'(iti_pkg::RequestDepth)) begin
            r_rmem[w_rslot] <= i_in.data.stamp;
        end
        unique case (r_rdsel)
            RD_OLD:    r_rdata <= r_smem[r_shead];
            RD_SECOND: r_rdata <= r_smem[w_slot1];
            default:   r_rdata <= r_smem[w_slotl];
        endcase
        // The sync time is held from the reads until the result is out.
        if (r_state == S_RD) begin
            r_t <= r_rmem[r_rhead];
        end
    end

    // r_vi holds the interpolated values in the order of vals: index 9 is
    // accel_x and index 0 is quat_w, so the quaternion sits at indexes 3..0.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_shead  <= '0;
            r_sfill  <= '0;
            r_rhead  <= '0;
            r_rfill  <= '0;
            r_ovalid <= 1'b0;
            r_rdsel  <= RD_OLD;
        end else begin
            if (r_ovalid && o_out.ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_in.data.opcode == iti_pkg::OP_SAMPLE) begin
                            r_shead <= w_head_eff;
                            r_sfill <= w_fill_eff + SCw'(1);
                        end else if (r_rfill != RCw'(iti_pkg::RequestDepth)) begin
                            r_rfill <= r_rfill + RCw'(1);
                        end
                        r_state <= S_RD;
                        r_rdsel <= RD_NEW;
                        r_idx   <= '0;
                    end
                end
                S_RD: begin
                    // Three reads: newest, oldest, second; r_idx steps them.
                    r_idx <= r_idx + 4'd1;
                    if (r_idx == 4'd0) begin
                        r_rdsel <= RD_OLD;
                    end else if (r_idx == 4'd1) begin
                        r_last  <= r_rdata.stamp;
                        r_rdsel <= RD_SECOND;
                    end else if (r_idx == 4'd2) begin
                        r_vf    <= r_rdata;
                        r_f     <= r_rdata.stamp;
                    end else begin
                        r_vb    <= r_rdata;
                        r_b     <= r_rdata.stamp;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_idx <= '0;
                    if (r_rfill == '0 || r_sfill < SCw'(2) || r_last < r_t) begin
                        r_state <= S_IDLE;
                    end else if (r_f > r_t) begin
                        r_rhead <= f_rwrap({1'b0, r_rhead} + (RAw+1)'(1));
                        r_rfill <= r_rfill - RCw'(1);
                        r_state <= S_RD;
                        r_rdsel <= RD_NEW;
                    end else begin
                        r_state <= S_PASS;
                    end
                end
                S_PASS: begin
                    if (!r_ovalid) begin
                        r_out    <= {iti_pkg::KIND_PASS, r_vf.stamp, r_vf.vals};
                        r_ovalid <= 1'b1;
                        r_shead  <= w_slot1;
                        r_sfill  <= r_sfill - SCw'(1);
                        r_rdsel  <= RD_NEW;
                        if (r_b < r_t) begin
                            r_state <= S_RD;
                        end else begin
                            r_rhead <= f_rwrap({1'b0, r_rhead} + (RAw+1)'(1));
                            r_rfill <= r_rfill - RCw'(1);
                            r_state <= S_LDIV;
                            r_idx   <= '0;
                        end
                    end
                end
                S_LDIV: begin
                    if (w_den == 32'd0) begin
                        r_vi[r_idx] <= w_vfc;
                        if (r_idx == 4'd9) begin
                            r_state <= S_SUMSQ;
                            r_idx   <= '0;
                            r_s     <= '0;
                        end else begin
                            r_idx <= r_idx + 4'd1;
                        end
                    end else begin
                        r_prod  <= 64'(w_lmag);
                        r_neg   <= w_lnum[49];
                        r_state <= S_DIVGO;
                    end
                end
                S_DIVGO: begin
                    r_state <= S_WDIV;
                end
                S_WDIV: begin
                    if (w_ddone) begin
                        r_vi[r_idx] <= r_neg ? -w_dquot[15:0] : w_dquot[15:0];
                        if (r_idx == 4'd9) begin
                            r_state <= S_SUMSQ;
                            r_idx   <= '0;
                            r_s     <= '0;
                        end else begin
                            r_idx   <= r_idx + 4'd1;
                            r_state <= S_LDIV;
                        end
                    end
                end
                S_SUMSQ: begin
                    r_s <= r_s + 34'(w_qsq);
                    if (r_idx == 4'd3) begin
                        r_idx   <= '0;
                        r_state <= S_NMUL;
                        r_lo    <= '0;
                        r_hi    <= 15'd16384;
                    end else begin
                        r_idx <= r_idx + 4'd1;
                    end
                end
                S_NMUL: begin
                    if (r_s == '0) begin
                        r_vi[r_idx] <= '0;
                        if (r_idx == 4'd3) r_state <= S_EMIT;
                        else r_idx <= r_idx + 4'd1;
                    end else if (r_lo == r_hi) begin
                        r_vi[r_idx] <= r_vi[r_idx][15] ? -{1'b0, r_lo} : {1'b0, r_lo};
                        r_lo <= '0;
                        r_hi <= 15'd16384;
                        if (r_idx == 4'd3) r_state <= S_EMIT;
                        else r_idx <= r_idx + 4'd1;
                    end else begin
                        r_prod  <= 64'(w_tsq);
                        r_a2    <= {2'd0, w_qsq, 30'd0};
                        r_state <= S_NCMP;
                    end
                end
                S_NCMP: begin
                    if (w_tts <= r_a2) r_lo <= w_mid;
                    else r_hi <= w_mid - 15'd1;
                    r_state <= S_NMUL;
                end
                S_EMIT: begin
                    if (!r_ovalid) begin
                        r_out    <= {iti_pkg::KIND_INTERP, r_t, r_vi};
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_out;
endmodule
`default_nettype wire

>>> rtl/iti_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iti_divider: restoring divider, one quotient bit per cycle
// Divides a 64-bit unsigned numerator by a 64-bit unsigned denominator.
// ----------------------------------------------------------------------------
module iti_divider (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_num,
    input  wire logic [63:0] i_den,
    output logic             o_done,
    output logic      [63:0] o_quot
);
    logic [63:0] r_quot;
    logic [63:0] r_rem;
    logic [63:0] r_den;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [64:0] w_trial;

    assign w_trial = {r_rem, r_quot[63]} - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd64;
                r_quot <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                // A remainder of 64 bits plus the shifted bit fits in 65.
                if (!w_trial[64] || r_rem[63]) begin
                    r_rem  <= w_trial[63:0];
                    r_quot <= {r_quot[62:0], 1'b1};
                end else begin
                    r_rem  <= {r_rem[62:0], r_quot[63]};
                    r_quot <= {r_quot[62:0], 1'b0};
                end
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule
`default_nettype wire
